// ----- src/gear_shift_scheduler_macros.svh -----
// ---------------------------------------------------------------------------
// Gear shift scheduler assertion macros
// Shared concurrent assertion forms used by the scheduler RTL.
// ---------------------------------------------------------------------------
`ifndef GEAR_SHIFT_SCHEDULER_MACROS_SVH
`define GEAR_SHIFT_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define GSS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define GSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/gss_pkg.sv -----
// ---------------------------------------------------------------------------
// Gear shift scheduler package
// Codes, thresholds and shared structs of the shift scheduler.
// ---------------------------------------------------------------------------
package gss_pkg;

    // Operation codes
    localparam logic [2:0] OP_TICK         = 3'd0;
    localparam logic [2:0] OP_UP_PRESS     = 3'd1;
    localparam logic [2:0] OP_UP_RELEASE   = 3'd2;
    localparam logic [2:0] OP_DOWN_PRESS   = 3'd3;
    localparam logic [2:0] OP_DOWN_RELEASE = 3'd4;

    // Lever positions
    localparam logic [2:0] LEVER_P     = 3'd0;
    localparam logic [2:0] LEVER_R     = 3'd1;
    localparam logic [2:0] LEVER_N     = 3'd2;
    localparam logic [2:0] LEVER_D     = 3'd3;
    localparam logic [2:0] LEVER_PLUS  = 3'd4;
    localparam logic [2:0] LEVER_MINUS = 3'd5;
    localparam logic [2:0] LEVER_SNV   = 3'd6;

    // Held lever state codes
    localparam logic [2:0] LSTATE_P     = 3'd0;
    localparam logic [2:0] LSTATE_R     = 3'd1;
    localparam logic [2:0] LSTATE_N     = 3'd2;
    localparam logic [2:0] LSTATE_DRIVE = 3'd4;
    localparam logic [2:0] LSTATE_SNV   = 3'd7;

    // Held gear display codes
    localparam logic [7:0] GCODE_BASE = 8'd48;
    localparam logic [7:0] GCODE_P    = 8'd80;
    localparam logic [7:0] GCODE_R    = 8'd82;
    localparam logic [7:0] GCODE_N    = 8'd78;
    localparam logic [7:0] GCODE_SNV  = 8'd255;

    // Drive programs
    localparam logic [2:0] PROG_SPORT   = 3'd0;
    localparam logic [2:0] PROG_COMFORT = 3'd1;
    localparam logic [2:0] PROG_AGILITY = 3'd2;
    localparam logic [2:0] PROG_MANUAL  = 3'd3;
    localparam logic [2:0] PROG_FAIL    = 3'd4;

    // Program display hints
    localparam logic [2:0] DISP_UP_HINT   = 3'd5;
    localparam logic [2:0] DISP_DOWN_HINT = 3'd6;

    // Gear bounds
    localparam logic [2:0] GEAR_LOW  = 3'd1;
    localparam logic [2:0] GEAR_HIGH = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_REDLINE      = 3'd0;
    localparam logic [2:0] CFG_RATIO_FIRST  = 3'd1;
    localparam logic [2:0] CFG_RATIO_SECOND = 3'd2;
    localparam logic [2:0] CFG_RATIO_THIRD  = 3'd3;
    localparam logic [2:0] CFG_RATIO_FOURTH = 3'd4;
    localparam logic [2:0] CFG_RATIO_FIFTH  = 3'd5;
    localparam logic [2:0] CFG_LIMP         = 3'd6;

    // Configuration reset values
    localparam logic [13:0] REDLINE_RESET = 14'd6500;
    localparam logic [15:0] RATIO1_RESET  = 16'd16105;
    localparam logic [15:0] RATIO2_RESET  = 16'd9863;
    localparam logic [15:0] RATIO3_RESET  = 16'd6087;
    localparam logic [15:0] RATIO4_RESET  = 16'd4096;
    localparam logic [15:0] RATIO5_RESET  = 16'd3400;
    localparam logic [15:0] RATIO_UNITY   = 16'd4096;

    // Shift thresholds per program
    localparam logic [13:0] SPORT_UP     = 14'd3000;
    localparam logic [13:0] SPORT_DOWN   = 14'd1200;
    localparam logic [13:0] COMFORT_UP   = 14'd2000;
    localparam logic [13:0] COMFORT_DOWN = 14'd1200;
    localparam logic [13:0] AGILITY_UP   = 14'd3700;
    localparam logic [13:0] AGILITY_DOWN = 14'd2200;
    localparam logic [13:0] MANUAL_UP    = 14'd9999;
    localparam logic [13:0] MANUAL_DOWN  = 14'd1000;
    localparam logic [13:0] FAIL_UP      = 14'd2500;
    localparam logic [13:0] FAIL_DOWN    = 14'd2000;

    // Manual hints and paddle limit
    localparam logic [14:0] HINT_MARGIN     = 15'd500;
    localparam logic [13:0] DOWN_HINT_RPM   = 14'd1500;
    localparam logic [29:0] PADDLE_UP_LIMIT = 30'd4915200;  // 1200 rpm in Q.12

    typedef struct packed {
        logic [13:0]      redline;
        logic [4:0][15:0] ratio;
        logic             limp;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  current_gear;
        logic [2:0]  program_mode;
        logic [2:0]  program_display;
        logic [7:0]  gear_display_code;
        logic [2:0]  lever_state_code;
        logic        shift_done;
        logic [15:0] forced_engine_rpm;
    } result_t;

endpackage

// ----- src/gss_core.sv -----
// ---------------------------------------------------------------------------
// Gear shift scheduler core
// Scheduler state and the single-pass decision logic for one transaction.
// ---------------------------------------------------------------------------
module gss_core
    import gss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [2:0]  operation,
    input  logic [13:0] crank_rpm,
    input  logic [13:0] shaft_rpm_in,
    input  logic [2:0]  lever_position,
    input  logic        program_button,
    input  cfg_t        cfg,
    output result_t     result
);

    // Ratio of a gear, unity for anything outside 1..5
    function automatic logic [15:0] ratio_of(input cfg_t c, input logic [2:0] g);
        logic [15:0] r;
        begin
            unique case (g)
                3'd1:    r = c.ratio[0];
                3'd2:    r = c.ratio[1];
                3'd3:    r = c.ratio[2];
                3'd4:    r = c.ratio[3];
                3'd5:    r = c.ratio[4];
                default: r = RATIO_UNITY;
            endcase
            return r;
        end
    endfunction

    logic [2:0]  gear_reg, gear_next;
    logic [2:0]  program_reg, program_next;
    logic [13:0] prev_rpm_reg, prev_rpm_next;
    logic [13:0] shaft_rpm_reg, shaft_rpm_next;
    logic        button_latch_reg, button_latch_next;
    logic        up_latch_reg, up_latch_next;
    logic        down_latch_reg, down_latch_next;
    logic [7:0]  gear_code_reg, gear_code_next;
    logic [2:0]  lever_code_reg, lever_code_next;

    logic [13:0] up_th, down_th;
    logic        is_tick, is_manual, in_d, at_top, at_bottom;
    logic        want_up, want_down, shifted;
    logic [2:0]  paddle_gear, mul_gear;
    logic [13:0] mul_a;
    logic [15:0] mul_b;
    logic [29:0] product;
    logic [2:0]  display;

    // Thresholds from the held program
    always_comb
    begin
        unique case (program_reg)
            PROG_SPORT:   begin up_th = SPORT_UP;   down_th = SPORT_DOWN;   end
            PROG_COMFORT: begin up_th = COMFORT_UP; down_th = COMFORT_DOWN; end
            PROG_AGILITY: begin up_th = AGILITY_UP; down_th = AGILITY_DOWN; end
            PROG_MANUAL:  begin up_th = MANUAL_UP;  down_th = MANUAL_DOWN;  end
            default:      begin up_th = FAIL_UP;    down_th = FAIL_DOWN;    end
        endcase
    end

    assign is_tick   = (operation == OP_TICK);
    assign is_manual = (program_reg == PROG_MANUAL);
    assign in_d      = (lever_position == LEVER_D);
    assign at_top    = (gear_reg == GEAR_HIGH);
    assign at_bottom = (gear_reg == GEAR_LOW);

    // Tick shift decision
    always_comb
    begin
        want_up   = 1'b0;
        want_down = 1'b0;
        if (is_manual)
        begin
            if (crank_rpm > up_th)
                want_up = 1'b1;
            else if (crank_rpm <= down_th)
                want_down = 1'b1;
        end
        else if (prev_rpm_reg > crank_rpm)
            want_down = (crank_rpm < down_th) && in_d;
        else
            want_up = (crank_rpm > up_th) && in_d;
    end

    // Shared multiplier: paddle check, and forced rpm of the new gear
    assign paddle_gear = (operation == OP_UP_PRESS) ? gear_reg + 3'd1 : gear_reg - 3'd1;
    always_comb
    begin
        if (is_tick)
        begin
            mul_a = shaft_rpm_in;
            priority if (want_up && !at_top)
                mul_gear = gear_reg + 3'd1;
            else if (want_down && !at_bottom)
                mul_gear = gear_reg - 3'd1;
            else
                mul_gear = gear_reg;
        end
        else
        begin
            mul_a    = shaft_rpm_reg;
            mul_gear = paddle_gear;
        end
    end
    assign mul_b   = ratio_of(cfg, mul_gear);
    assign product = 30'(mul_a) * 30'(mul_b);

    // Next state
    always_comb
    begin
        gear_next         = gear_reg;
        program_next      = program_reg;
        prev_rpm_next     = prev_rpm_reg;
        shaft_rpm_next    = shaft_rpm_reg;
        button_latch_next = button_latch_reg;
        up_latch_next     = up_latch_reg;
        down_latch_next   = down_latch_reg;
        gear_code_next    = gear_code_reg;
        lever_code_next   = lever_code_reg;
        shifted           = 1'b0;
        display           = program_reg;

        unique case (operation)
            OP_TICK:
            begin
                shaft_rpm_next = shaft_rpm_in;
                prev_rpm_next  = crank_rpm;
                shifted        = (mul_gear != gear_reg);
                gear_next      = mul_gear;

                // Manual hints look at the gear after the shift
                if (is_manual && ({1'b0, crank_rpm} + HINT_MARGIN >= {1'b0, cfg.redline})
                    && (gear_next != GEAR_HIGH))
                    display = DISP_UP_HINT;
                else if (is_manual && (crank_rpm <= DOWN_HINT_RPM)
                    && (gear_next != GEAR_LOW))
                    display = DISP_DOWN_HINT;

                // Held lever and gear codes; other positions keep them
                unique case (lever_position)
                    LEVER_P:
                    begin
                        lever_code_next = LSTATE_P;
                        gear_code_next  = GCODE_P;
                    end
                    LEVER_R:
                    begin
                        lever_code_next = LSTATE_R;
                        gear_code_next  = GCODE_R;
                    end
                    LEVER_N:
                    begin
                        lever_code_next = LSTATE_N;
                        gear_code_next  = GCODE_N;
                    end
                    LEVER_D, LEVER_PLUS, LEVER_MINUS:
                    begin
                        lever_code_next = LSTATE_DRIVE;
                        gear_code_next  = GCODE_BASE + {5'd0, gear_next};
                    end
                    LEVER_SNV:
                    begin
                        lever_code_next = LSTATE_SNV;
                        gear_code_next  = GCODE_SNV;
                    end
                    default:
                    begin
                    end
                endcase

                // Program button: one step per press, Fail under limp
                if (program_button)
                begin
                    if (cfg.limp)
                        program_next = PROG_FAIL;
                    else if (!button_latch_reg)
                    begin
                        button_latch_next = 1'b1;
                        if (program_reg == PROG_MANUAL)
                            program_next = PROG_SPORT;
                        else if (program_reg != PROG_FAIL)
                            program_next = program_reg + 3'd1;
                    end
                end
                else
                    button_latch_next = 1'b0;
            end
            OP_UP_PRESS:
            begin
                if (!at_top && !up_latch_reg && (product > PADDLE_UP_LIMIT))
                begin
                    gear_next     = paddle_gear;
                    shifted       = 1'b1;
                    up_latch_next = 1'b1;
                end
            end
            OP_UP_RELEASE:
                up_latch_next = 1'b0;
            OP_DOWN_PRESS:
            begin
                if (!at_bottom && !down_latch_reg
                    && (product <= {4'd0, cfg.redline, 12'd0}))
                begin
                    gear_next       = paddle_gear;
                    shifted         = 1'b1;
                    down_latch_next = 1'b1;
                end
            end
            OP_DOWN_RELEASE:
                down_latch_next = 1'b0;
            default:
            begin
            end
        endcase
    end

    // Result of this transaction
    always_comb
    begin
        result.current_gear      = gear_next;
        result.program_mode      = program_next;
        result.program_display   = display;
        result.gear_display_code = gear_code_next;
        result.lever_state_code  = lever_code_next;
        result.shift_done        = shifted;
        if (!shifted)
            result.forced_engine_rpm = 16'd0;
        else if (|product[29:28])
            result.forced_engine_rpm = 16'hFFFF;
        else
            result.forced_engine_rpm = product[27:12];
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_reg         <= GEAR_LOW;
            program_reg      <= PROG_SPORT;
            prev_rpm_reg     <= 14'd0;
            shaft_rpm_reg    <= 14'd0;
            button_latch_reg <= 1'b0;
            up_latch_reg     <= 1'b0;
            down_latch_reg   <= 1'b0;
            gear_code_reg    <= 8'd0;
            lever_code_reg   <= 3'd0;
        end
        else if (accept)
        begin
            gear_reg         <= gear_next;
            program_reg      <= program_next;
            prev_rpm_reg     <= prev_rpm_next;
            shaft_rpm_reg    <= shaft_rpm_next;
            button_latch_reg <= button_latch_next;
            up_latch_reg     <= up_latch_next;
            down_latch_reg   <= down_latch_next;
            gear_code_reg    <= gear_code_next;
            lever_code_reg   <= lever_code_next;
        end
    end

endmodule

// ----- src/gear_shift_scheduler.sv -----
// ---------------------------------------------------------------------------
// Gear shift scheduler
// Five-speed shift scheduler with configuration registers and output skid.
// ---------------------------------------------------------------------------
// Each transaction (tick or paddle event) is decided in the cycle it is
// accepted and goes to the output register, or to the skid while the output
// stalls; the block takes one transaction per clock while in_stall is low.
// The single 14x16 multiplier in the core serves both the paddle ratio check
// and the forced engine rpm. A two-entry output buffer (output register plus
// skid) lets input keep flowing while one result waits; in_stall rises only
// when both entries are full. Configuration writes take effect on the next
// transaction and should be done while the block is idle.
// ---------------------------------------------------------------------------
`include "gear_shift_scheduler_macros.svh"

module gear_shift_scheduler
    import gss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [13:0] crank_rpm,
    input  logic [13:0] shaft_rpm_in,
    input  logic [2:0]  lever_position,
    input  logic        program_button,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  current_gear,
    output logic [2:0]  program_mode,
    output logic [2:0]  program_display,
    output logic [7:0]  gear_display_code,
    output logic [2:0]  lever_state_code,
    output logic        shift_done,
    output logic [15:0] forced_engine_rpm
);

    cfg_t    cfg_reg;
    result_t result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    accept;
    logic    out_free;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.redline  <= REDLINE_RESET;
            cfg_reg.ratio[0] <= RATIO1_RESET;
            cfg_reg.ratio[1] <= RATIO2_RESET;
            cfg_reg.ratio[2] <= RATIO3_RESET;
            cfg_reg.ratio[3] <= RATIO4_RESET;
            cfg_reg.ratio[4] <= RATIO5_RESET;
            cfg_reg.limp     <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_REDLINE:      cfg_reg.redline  <= cfg_data[13:0];
                CFG_RATIO_FIRST:  cfg_reg.ratio[0] <= cfg_data;
                CFG_RATIO_SECOND: cfg_reg.ratio[1] <= cfg_data;
                CFG_RATIO_THIRD:  cfg_reg.ratio[2] <= cfg_data;
                CFG_RATIO_FOURTH: cfg_reg.ratio[3] <= cfg_data;
                CFG_RATIO_FIFTH:  cfg_reg.ratio[4] <= cfg_data;
                CFG_LIMP:         cfg_reg.limp     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Decision logic and scheduler state
    gss_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .operation      (operation),
        .crank_rpm      (crank_rpm),
        .shaft_rpm_in   (shaft_rpm_in),
        .lever_position (lever_position),
        .program_button (program_button),
        .cfg            (cfg_reg),
        .result         (result)
    );

    // Output buffer valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= result;
        end
        else if (accept)
            skid_reg <= result;
    end

    assign out_valid         = out_valid_reg;
    assign current_gear      = out_reg.current_gear;
    assign program_mode      = out_reg.program_mode;
    assign program_display   = out_reg.program_display;
    assign gear_display_code = out_reg.gear_display_code;
    assign lever_state_code  = out_reg.lever_state_code;
    assign shift_done        = out_reg.shift_done;
    assign forced_engine_rpm = out_reg.forced_engine_rpm;

    // Checks
    `GSS_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `GSS_ASSERT_IMPL(a_gear_range, clk, rst_n, out_valid_reg, (current_gear >= GEAR_LOW) && (current_gear <= GEAR_HIGH), "gear out of range")
    `GSS_ASSERT_IMPL(a_forced_zero, clk, rst_n, out_valid_reg && !shift_done, forced_engine_rpm == 16'd0, "forced rpm without shift")
    `GSS_ASSERT_NEXT(a_stall_keeps, clk, rst_n, out_valid_reg && out_stall, out_valid_reg, "result dropped while stalled")

endmodule
